/* sv/tisp_pkg.sv */
// Shared constants, command codes, state type and store control struct of the trie core.
package tisp_pkg;

   localparam int MAX_NODES_DEF = 1024;
   localparam int ALPHABET_DEF  = 26;

   localparam int CMD_W    = 2;
   localparam int LETTER_W = 5;
   localparam int ALPH_W   = 9;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_MARK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic link_rd_en;
      logic link_wr_en;
      logic mark_rd_en;
      logic mark_wr_en;
      logic mark_wr_data;
   } store_ctrl_type;

endpackage

/* sv/trie_insert_search_prefix_core.sv */
// Top level of the trie core: stream ports, sequencer and node table.
// Words enter one letter per item with an insert, search or prefix command, and the item
// marked last gives one result. A letter item first reads the child link of the current
// node from the link memory, then follows it or writes a new link from the free node
// counter. The last item of a word then reads the word end mark of the reached node and
// registers the result; an empty last item goes straight to the mark read, and an ignored
// item leaves the block ready. After reset the block runs a clearing pass over all
// MAX_NODES * ALPHABET link slots of the node table and accepts no item until it ends. A
// result waits in an output register while the next word's letters are taken.
module trie_insert_search_prefix_core #(
   parameter int MAX_NODES = tisp_pkg::MAX_NODES_DEF,
   parameter int ALPHABET  = tisp_pkg::ALPHABET_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [4:0] letter, [7:5] zero
   input  logic [2:0] req_tuser,  // [1:0] command, [2] has_letter
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [0] hit, [1] overflow, [7:2] zero
   output logic [1:0] rsp_tuser   // [1:0] command_echo
);

   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int SLOT_W = $clog2(MAX_NODES * ALPHABET);

   tisp_pkg::store_ctrl_type store_ctrl;
   logic [SLOT_W-1:0] link_rd_addr;
   logic [SLOT_W-1:0] link_wr_addr;
   logic [NODE_W-1:0] link_wr_data;
   logic [NODE_W-1:0] link_rd_data;
   logic [NODE_W-1:0] mark_rd_addr;
   logic [NODE_W-1:0] mark_wr_addr;
   logic              mark_rd_data;
   logic              rsp_hit;
   logic              rsp_overflow;

   tisp_ctrl #(
      .MAX_NODES (MAX_NODES),
      .ALPHABET  (ALPHABET)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_command    (req_tuser[1:0]),
      .req_letter     (req_tdata[4:0]),
      .req_has_letter (req_tuser[2]),
      .req_last       (req_tlast),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_hit        (rsp_hit),
      .rsp_overflow   (rsp_overflow),
      .rsp_command    (rsp_tuser),
      .store_ctrl     (store_ctrl),
      .link_rd_addr   (link_rd_addr),
      .link_wr_addr   (link_wr_addr),
      .link_wr_data   (link_wr_data),
      .link_rd_data   (link_rd_data),
      .mark_rd_addr   (mark_rd_addr),
      .mark_wr_addr   (mark_wr_addr),
      .mark_rd_data   (mark_rd_data)
   );

   tisp_store #(
      .MAX_NODES (MAX_NODES),
      .ALPHABET  (ALPHABET)
   ) u_store (
      .clock        (clock),
      .ctrl         (store_ctrl),
      .link_rd_addr (link_rd_addr),
      .link_wr_addr (link_wr_addr),
      .link_wr_data (link_wr_data),
      .link_rd_data (link_rd_data),
      .mark_rd_addr (mark_rd_addr),
      .mark_wr_addr (mark_wr_addr),
      .mark_rd_data (mark_rd_data)
   );

   assign rsp_tdata = {6'd0, rsp_overflow, rsp_hit};

endmodule

/* sv/tisp_store.sv */
// Child link table and word end marks, each a memory with separate read and write ports and registered read data.
module tisp_store #(
   parameter int MAX_NODES = tisp_pkg::MAX_NODES_DEF,
   parameter int ALPHABET  = tisp_pkg::ALPHABET_DEF,
   localparam int NODE_W   = $clog2(MAX_NODES),
   localparam int TOTAL    = MAX_NODES * ALPHABET,
   localparam int SLOT_W   = $clog2(TOTAL)
) (
   input  logic                    clock,
   input  tisp_pkg::store_ctrl_type ctrl,
   input  logic [SLOT_W-1:0]       link_rd_addr,
   input  logic [SLOT_W-1:0]       link_wr_addr,
   input  logic [NODE_W-1:0]       link_wr_data,
   output logic [NODE_W-1:0]       link_rd_data,
   input  logic [NODE_W-1:0]       mark_rd_addr,
   input  logic [NODE_W-1:0]       mark_wr_addr,
   output logic                    mark_rd_data
);

   logic [NODE_W-1:0] link_mem [TOTAL];
   logic              mark_mem [MAX_NODES];
   logic [NODE_W-1:0] link_rd_ff;
   logic              mark_rd_ff;

   always_ff @(posedge clock) begin
      if (ctrl.link_wr_en) begin
         link_mem[link_wr_addr] <= link_wr_data;
      end
      if (ctrl.link_rd_en) begin
         link_rd_ff <= link_mem[link_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mark_wr_en) begin
         mark_mem[mark_wr_addr] <= ctrl.mark_wr_data;
      end
      if (ctrl.mark_rd_en) begin
         mark_rd_ff <= mark_mem[mark_rd_addr];
      end
   end

   assign link_rd_data = link_rd_ff;
   assign mark_rd_data = mark_rd_ff;

endmodule

/* sv/tisp_ctrl.sv */
// Sequencer of the trie walk: clearing pass, link lookup and allocation, word end and result.
module tisp_ctrl #(
   parameter int MAX_NODES = tisp_pkg::MAX_NODES_DEF,
   parameter int ALPHABET  = tisp_pkg::ALPHABET_DEF,
   localparam int NODE_W   = $clog2(MAX_NODES),
   localparam int TOTAL    = MAX_NODES * ALPHABET,
   localparam int SLOT_W   = $clog2(TOTAL),
   localparam int FREE_W   = NODE_W + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tisp_pkg::CMD_W-1:0]    req_command,
   input  logic [tisp_pkg::LETTER_W-1:0] req_letter,
   input  logic                          req_has_letter,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic                          rsp_overflow,
   output logic [tisp_pkg::CMD_W-1:0]    rsp_command,
   output tisp_pkg::store_ctrl_type      store_ctrl,
   output logic [SLOT_W-1:0]             link_rd_addr,
   output logic [SLOT_W-1:0]             link_wr_addr,
   output logic [NODE_W-1:0]             link_wr_data,
   input  logic [NODE_W-1:0]             link_rd_data,
   output logic [NODE_W-1:0]             mark_rd_addr,
   output logic [NODE_W-1:0]             mark_wr_addr,
   input  logic                          mark_rd_data
);

   localparam logic [tisp_pkg::ALPH_W-1:0] ALPHA_L = tisp_pkg::ALPH_W'(ALPHABET);

   tisp_pkg::state_type state_ff, state_in;

   logic [SLOT_W-1:0]             clr_ff, clr_in;
   logic [tisp_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [tisp_pkg::LETTER_W-1:0] letter_ff, letter_in;
   logic                          last_ff, last_in;
   logic [SLOT_W-1:0]             slot_ff, slot_in;
   logic [NODE_W-1:0]             cursor_ff, cursor_in;
   logic [FREE_W-1:0]             free_ff, free_in;
   logic                          miss_ff, miss_in;
   logic                          fail_ff, fail_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          hit_ff, hit_in;
   logic                          ovf_ff, ovf_in;
   logic [tisp_pkg::CMD_W-1:0]    echo_ff, echo_in;

   logic              accept;
   logic              cmd_ok;
   logic              clr_done;
   logic              dead;
   logic              letter_ok;
   logic              advance;
   logic [SLOT_W-1:0] slot_calc;

   assign req_ready = (state_ff == tisp_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign cmd_ok    = (req_command == tisp_pkg::CMD_INSERT) ||
                      (req_command == tisp_pkg::CMD_SEARCH) ||
                      (req_command == tisp_pkg::CMD_PREFIX);
   assign clr_done  = (clr_ff == SLOT_W'(TOTAL - 1));
   assign dead      = miss_ff || fail_ff;
   assign letter_ok = (tisp_pkg::ALPH_W'(letter_ff) < ALPHA_L);
   assign advance   = !rsp_valid_ff || rsp_ready;
   // The slot of a letter sits at cursor times alphabet size plus the letter.
   assign slot_calc = SLOT_W'(cursor_ff) * SLOT_W'(ALPHABET) + SLOT_W'(req_letter);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tisp_pkg::ST_CLEAR: begin
            if (clr_done) begin
               state_in = tisp_pkg::ST_IDLE;
            end
         end
         tisp_pkg::ST_IDLE: begin
            if (accept && cmd_ok) begin
               if (req_has_letter) begin
                  state_in = tisp_pkg::ST_WALK;
               end else if (req_last) begin
                  state_in = tisp_pkg::ST_MARK;
               end
            end
         end
         tisp_pkg::ST_WALK: begin
            state_in = last_ff ? tisp_pkg::ST_MARK : tisp_pkg::ST_IDLE;
         end
         tisp_pkg::ST_MARK: begin
            state_in = tisp_pkg::ST_RESP;
         end
         tisp_pkg::ST_RESP: begin
            if (advance) begin
               state_in = tisp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tisp_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      letter_in    = letter_ff;
      last_in      = last_ff;
      slot_in      = slot_ff;
      cursor_in    = cursor_ff;
      free_in      = free_ff;
      miss_in      = miss_ff;
      fail_in      = fail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      hit_in       = hit_ff;
      ovf_in       = ovf_ff;
      echo_in      = echo_ff;
      store_ctrl   = '0;
      link_rd_addr = slot_calc;
      link_wr_addr = slot_ff;
      link_wr_data = free_ff[NODE_W-1:0];
      mark_rd_addr = cursor_ff;
      mark_wr_addr = cursor_ff;
      unique case (state_ff)
         tisp_pkg::ST_CLEAR: begin
            clr_in                  = clr_ff + SLOT_W'(1);
            store_ctrl.link_wr_en   = 1'b1;
            link_wr_addr            = clr_ff;
            link_wr_data            = '0;
            store_ctrl.mark_wr_en   = (clr_ff < SLOT_W'(MAX_NODES));
            store_ctrl.mark_wr_data = 1'b0;
            mark_wr_addr            = clr_ff[NODE_W-1:0];
         end
         tisp_pkg::ST_IDLE: begin
            if (accept && cmd_ok) begin
               cmd_in                = req_command;
               letter_in             = req_letter;
               last_in               = req_last;
               slot_in               = slot_calc;
               store_ctrl.link_rd_en = req_has_letter;
            end
         end
         tisp_pkg::ST_WALK: begin
            if (!dead) begin
               if (!letter_ok) begin
                  if (cmd_ff == tisp_pkg::CMD_INSERT) begin
                     fail_in = 1'b1;
                  end else begin
                     miss_in = 1'b1;
                  end
               end else if (link_rd_data != '0) begin
                  cursor_in = link_rd_data;
               end else if (cmd_ff != tisp_pkg::CMD_INSERT) begin
                  miss_in = 1'b1;
               end else if (free_ff >= FREE_W'(MAX_NODES)) begin
                  fail_in = 1'b1;
               end else begin
                  // Missing link on insert: hang the next free node here.
                  store_ctrl.link_wr_en = 1'b1;
                  cursor_in             = free_ff[NODE_W-1:0];
                  free_in               = free_ff + FREE_W'(1);
               end
            end
         end
         tisp_pkg::ST_MARK: begin
            store_ctrl.mark_rd_en = 1'b1;
         end
         tisp_pkg::ST_RESP: begin
            if (advance) begin
               rsp_valid_in = 1'b1;
               echo_in      = cmd_ff;
               ovf_in       = 1'b0;
               hit_in       = !dead;
               if (cmd_ff == tisp_pkg::CMD_INSERT) begin
                  ovf_in                  = dead;
                  store_ctrl.mark_wr_en   = !dead;
                  store_ctrl.mark_wr_data = 1'b1;
               end else if (cmd_ff == tisp_pkg::CMD_SEARCH) begin
                  hit_in = !dead && mark_rd_data;
               end
               cursor_in = '0;
               miss_in   = 1'b0;
               fail_in   = 1'b0;
            end
         end
         default: begin
            store_ctrl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tisp_pkg::ST_CLEAR;
         clr_ff       <= '0;
         cursor_ff    <= '0;
         free_ff      <= FREE_W'(1);
         miss_ff      <= 1'b0;
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cursor_ff    <= cursor_in;
         free_ff      <= free_in;
         miss_ff      <= miss_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      letter_ff <= letter_in;
      last_ff   <= last_in;
      slot_ff   <= slot_in;
      hit_ff    <= hit_in;
      ovf_ff    <= ovf_in;
      echo_ff   <= echo_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = hit_ff;
   assign rsp_overflow = ovf_ff;
   assign rsp_command  = echo_ff;

endmodule

/* sv/tisp_checker.sv */
// Port-level checks of the trie core, bound to its top level.
module tisp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic [2:0] req_tuser,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser
);

   // A held result keeps its contents until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Overflow only answers an insert, and then the hit is low.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tuser == tisp_pkg::CMD_INSERT && !rsp_tdata[0])
      else $error("overflow on a result that is not a failed insert");

   // The clearing pass starts at reset: nothing is accepted or shown.
   assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("block active right after reset");

   // A letter or a word end keeps the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[1:0] <= tisp_pkg::CMD_PREFIX &&
      (req_tuser[2] || req_tlast)
      |=> !req_tready)
      else $error("item taken without walk cycles");

   // A new result never follows directly on an item that is not last.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast |=> !$rose(rsp_tvalid))
      else $error("result raised by an item that is not last");

endmodule

bind trie_insert_search_prefix_core tisp_checker u_tisp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
